// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the wave equation stencil RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/wes_pkg.sv =====
// Shared types, codes and constants of the wave equation stencil.
`timescale 1ns / 1ps
`default_nettype none

package wes_pkg;

   localparam int CMD_W      = 2;
   localparam int IDX_W      = 10;
   localparam int SAMPLE_W   = 24;
   localparam int PC_W       = 11;
   localparam int STEP_W     = 16;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TDATA_W    = 40;

   localparam logic [CMD_W-1:0] CMD_LOAD_PREV = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_CUR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

   localparam logic KIND_RUN_DONE  = 1'b0;
   localparam logic KIND_READ_DATA = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUPLING    = 2'd2;

   localparam logic [PC_W-1:0]   POINT_COUNT_RESET = 11'd1024;
   localparam logic [STEP_W-1:0] STEP_COUNT_RESET  = 16'd1;
   localparam logic [COEF_W-1:0] COUPLING_RESET    = 16'd9830;

   typedef struct packed {
      logic valid;
      logic emit;
      logic fixed_pt;
   } wes_ctl_type;

   typedef struct packed {
      logic busy;
      logic wr_valid;
   } wes_stat_type;

   function automatic logic [1:0] rot_next(input logic [1:0] r);
      return (r == 2'd2) ? 2'd0 : r + 2'd1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wave_equation_stencil_1d.sv =====
// Top level of the one-dimensional wave equation stencil engine.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// A load writes its sample into the selected bank as it is transferred. A read
// registers its sample in the bank, then in the response register once it is free.
// A run streams the current and previous banks through one shared stencil pipeline,
// one point per cycle, and lets that pipeline drain before the banks rotate. A done
// response follows the last step. Requests are refused during a read or a run.

module wave_equation_stencil_1d #(
   parameter int MAX_POINTS  = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_index [9:0], sample_in [33:10], zero fill [39:34]
   input  logic [wes_pkg::TDATA_W-1:0]       req_tdata,
   // cmd [1:0]
   input  logic [wes_pkg::CMD_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // point_out [9:0], sample_out [33:10], zero fill [39:34]
   output logic [wes_pkg::TDATA_W-1:0]       rsp_tdata,
   // kind [0]
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wes_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wes_pkg::CSR_DATA_W-1:0]    csr_data
);

   import wes_pkg::*;

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int NW  = (CW > PC_W) ? CW : PC_W;
   localparam int IXW = (AW > IDX_W) ? AW : IDX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          rot_ff, rot_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic [STEP_W-1:0]   step_cfg_ff, step_cfg_in;
   logic [COEF_W-1:0]   coupling_ff, coupling_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   wes_ctl_type         s1_ctl_ff, s1_ctl_in;
   logic [AW-1:0]       s1_addr_ff, s1_addr_in;
   logic                rd_range_ff, rd_range_in;
   logic [IDX_W-1:0]    rd_point_ff, rd_point_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]    rsp_point_ff, rsp_point_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic [IDX_W-1:0]              req_point;
   logic signed [SAMPLE_W-1:0]    req_sample;
   logic [IXW-1:0]                req_idx_ext;
   logic [AW-1:0]                 req_addr;
   logic                          req_in_range;
   logic                          req_fire, csr_fire, rsp_free;
   logic [1:0]                    prev_bank, cur_bank, nxt_bank;
   logic [NW-1:0]                 pc_ext, n_clamped;
   logic [CW-1:0]                 pidx;
   logic                          rd_go;
   logic [AW-1:0]                 rd_addr;
   logic                          load_go;
   logic                          wr_valid;
   logic [1:0]                    wr_bank;
   logic [AW-1:0]                 wr_addr;
   logic signed [SAMPLE_BITS-1:0] wr_data;
   logic signed [SAMPLE_BITS-1:0] load_sample;
   logic signed [SAMPLE_BITS-1:0] read_raw;
   logic signed [SAMPLE_W-1:0]    read_sample;
   logic signed [SAMPLE_BITS-1:0] bank_rd_data [3];
   wes_stat_type                  alu_stat;
   logic [AW-1:0]                 alu_wr_addr;
   logic signed [SAMPLE_BITS-1:0] alu_wr_data;

   assign req_point    = req_tdata[IDX_W-1:0];
   assign req_sample   = req_tdata[IDX_W+SAMPLE_W-1:IDX_W];
   assign req_idx_ext  = IXW'(req_point);
   assign req_addr     = req_idx_ext[AW-1:0];
   assign req_in_range = 32'(req_point) < 32'(MAX_POINTS);
   assign req_fire     = req_tvalid && req_tready;
   assign csr_fire     = csr_valid && csr_ready;
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   assign prev_bank = rot_ff;
   assign cur_bank  = rot_next(rot_ff);
   assign nxt_bank  = rot_next(cur_bank);

   assign pc_ext    = NW'(pc_ff);
   assign n_clamped = ((pc_ext == '0) || (pc_ext > NW'(MAX_POINTS))) ? NW'(MAX_POINTS) : pc_ext;
   assign pidx      = rd_idx_ff - CW'(1);

   assign rd_go   = (state_ff == ST_STEP) || (req_fire && (req_tuser == CMD_READ));
   assign rd_addr = (state_ff == ST_STEP)
                    ? ((32'(rd_idx_ff) < 32'(MAX_POINTS)) ? rd_idx_ff[AW-1:0] : '0)
                    : req_addr;

   assign load_go  = req_fire && req_in_range
                     && ((req_tuser == CMD_LOAD_PREV) || (req_tuser == CMD_LOAD_CUR));
   assign wr_valid = load_go || alu_stat.wr_valid;
   assign wr_bank  = alu_stat.wr_valid ? nxt_bank
                     : ((req_tuser == CMD_LOAD_PREV) ? prev_bank : cur_bank);
   assign wr_addr  = alu_stat.wr_valid ? alu_wr_addr : req_addr;
   assign wr_data  = alu_stat.wr_valid ? alu_wr_data : load_sample;
   assign read_raw = rd_range_ff ? bank_rd_data[cur_bank] : '0;

   wes_sat #(
      .IN_BITS  (SAMPLE_W),
      .OUT_BITS (SAMPLE_BITS)
   ) u_load_sat (
      .in_val  (req_sample),
      .out_val (load_sample)
   );

   wes_sat #(
      .IN_BITS  (SAMPLE_BITS),
      .OUT_BITS (SAMPLE_W)
   ) u_read_sat (
      .in_val  (read_raw),
      .out_val (read_sample)
   );

   for (genvar b = 0; b < 3; b++) begin : g_bank
      wes_bank #(
         .DEPTH (MAX_POINTS),
         .WIDTH (SAMPLE_BITS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_valid && (wr_bank == 2'(b))),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_go),
         .rd_addr (rd_addr),
         .rd_data (bank_rd_data[b])
      );
   end

   wes_alu #(
      .ADDR_BITS   (AW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_alu (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (s1_ctl_ff),
      .addr_in  (s1_addr_ff),
      .cur_in   (bank_rd_data[cur_bank]),
      .prev_in  (bank_rd_data[prev_bank]),
      .coupling (coupling_ff),
      .stat     (alu_stat),
      .wr_addr  (alu_wr_addr),
      .wr_data  (alu_wr_data)
   );

   always_comb begin
      state_in      = state_ff;
      rot_in        = rot_ff;
      pc_in         = pc_ff;
      step_cfg_in   = step_cfg_ff;
      coupling_in   = coupling_ff;
      n_in          = n_ff;
      rd_idx_in     = rd_idx_ff;
      steps_in      = steps_ff;
      rd_range_in   = rd_range_ff;
      rd_point_in   = rd_point_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_point_in  = rsp_point_ff;
      rsp_sample_in = rsp_sample_ff;

      s1_ctl_in.valid    = (state_ff == ST_STEP);
      s1_ctl_in.emit     = (rd_idx_ff != '0);
      s1_ctl_in.fixed_pt = (rd_idx_ff == CW'(1)) || (rd_idx_ff == n_ff);
      s1_addr_in         = pidx[AW-1:0];

      if (csr_fire) begin
         unique case (csr_index)
            REG_POINT_COUNT: pc_in       = csr_data[PC_W-1:0];
            REG_STEP_COUNT:  step_cfg_in = csr_data[STEP_W-1:0];
            REG_COUPLING:    coupling_in = csr_data[COEF_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser) inside
                  CMD_LOAD_PREV, CMD_LOAD_CUR: ;
                  CMD_RUN: begin
                     n_in      = n_clamped[CW-1:0];
                     steps_in  = step_cfg_ff;
                     rd_idx_in = '0;
                     state_in  = (step_cfg_ff == '0) ? ST_DONE : ST_STEP;
                  end
                  default: begin
                     rd_range_in = req_in_range;
                     rd_point_in = req_point;
                     state_in    = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_READ_DATA;
               rsp_point_in  = rd_point_ff;
               rsp_sample_in = read_sample;
               state_in      = ST_IDLE;
            end
         end
         ST_STEP: begin
            rd_idx_in = rd_idx_ff + CW'(1);
            if (rd_idx_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ctl_ff.valid && !alu_stat.busy) begin
               rot_in    = rot_next(rot_ff);
               steps_in  = steps_ff - STEP_W'(1);
               rd_idx_in = '0;
               state_in  = (steps_ff == STEP_W'(1)) ? ST_DONE : ST_STEP;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_RUN_DONE;
               rsp_point_in  = '0;
               rsp_sample_in = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rot_ff          <= 2'd0;
         pc_ff           <= POINT_COUNT_RESET;
         step_cfg_ff     <= STEP_COUNT_RESET;
         coupling_ff     <= COUPLING_RESET;
         s1_ctl_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rot_ff          <= rot_in;
         pc_ff           <= pc_in;
         step_cfg_ff     <= step_cfg_in;
         coupling_ff     <= coupling_in;
         s1_ctl_ff.valid <= s1_ctl_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
      end
      s1_ctl_ff.emit     <= s1_ctl_in.emit;
      s1_ctl_ff.fixed_pt <= s1_ctl_in.fixed_pt;
      s1_addr_ff         <= s1_addr_in;
      n_ff               <= n_in;
      rd_idx_ff          <= rd_idx_in;
      steps_ff           <= steps_in;
      rd_range_ff        <= rd_range_in;
      rd_point_ff        <= rd_point_in;
      rsp_kind_ff        <= rsp_kind_in;
      rsp_point_ff       <= rsp_point_in;
      rsp_sample_ff      <= rsp_sample_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {(TDATA_W - IDX_W - SAMPLE_W)'(0), rsp_sample_ff, rsp_point_ff};

   `ASSERT_CLK(a_wr_only_in_run, clock, reset,
      alu_stat.wr_valid |-> (state_ff == ST_STEP || state_ff == ST_DRAIN),
      "stencil write outside a run")
   `ASSERT_CLK(a_rot_at_step_end, clock, reset,
      (!$past(reset) && !$stable(rot_ff)) |-> ($past(state_ff) == ST_DRAIN),
      "bank rotation outside the end of a step")
   `ASSERT_NEVER(a_no_req_while_busy, clock, reset,
      (alu_stat.busy || s1_ctl_ff.valid) && req_tready,
      "request accepted while the stencil pipeline is busy")

endmodule

`default_nettype wire

// ===== rtl/core/wes_sat.sv =====
// Signed saturation of a sample to a narrower or equal width; a wider output is sign-extended.
`timescale 1ns / 1ps
`default_nettype none

module wes_sat #(
   parameter int IN_BITS  = 28,
   parameter int OUT_BITS = 24
) (
   input  logic signed [IN_BITS-1:0]  in_val,
   output logic signed [OUT_BITS-1:0] out_val
);

   localparam int XW = (IN_BITS > OUT_BITS) ? IN_BITS : OUT_BITS;

   logic signed [XW-1:0] ext;
   logic signed [XW-1:0] hi;
   logic                 fits;

   assign ext     = XW'(in_val);
   assign hi      = ext >>> (OUT_BITS - 1);
   assign fits    = (hi == '0) || (hi == '1);
   assign out_val = fits ? ext[OUT_BITS-1:0]
                         : {ext[XW-1], {(OUT_BITS-1){~ext[XW-1]}}};

endmodule

`default_nettype wire

// ===== rtl/core/wes_bank.sv =====
// One wave buffer bank: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module wes_bank #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wes_alu.sv =====
// Shared stencil unit: sliding window, coupling multiply, round and saturate.
`timescale 1ns / 1ps
`default_nettype none

module wes_alu #(
   parameter int ADDR_BITS   = 10,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wes_pkg::wes_ctl_type          ctl_in,
   input  logic [ADDR_BITS-1:0]          addr_in,
   input  logic signed [SAMPLE_BITS-1:0] cur_in,
   input  logic signed [SAMPLE_BITS-1:0] prev_in,
   input  logic [wes_pkg::COEF_W-1:0]    coupling,
   output wes_pkg::wes_stat_type         stat,
   output logic [ADDR_BITS-1:0]          wr_addr,
   output logic signed [SAMPLE_BITS-1:0] wr_data
);

   import wes_pkg::*;

   localparam int LW = SAMPLE_BITS + 2;
   localparam int PW = SAMPLE_BITS + 19;
   localparam int RW = PW - 16;
   localparam int SW = SAMPLE_BITS + 4;

   logic signed [SAMPLE_BITS-1:0] w1_ff, w2_ff, pv_ff;

   logic                          a_valid_ff, a_fixed_ff;
   logic [ADDR_BITS-1:0]          a_addr_ff;
   logic signed [LW-1:0]          a_lap_ff, a_base_ff;
   logic signed [SAMPLE_BITS-1:0] a_copy_ff;

   logic                          b_valid_ff, b_fixed_ff;
   logic [ADDR_BITS-1:0]          b_addr_ff;
   logic signed [PW-1:0]          b_prod_ff;
   logic signed [LW-1:0]          b_base_ff;
   logic signed [SAMPLE_BITS-1:0] b_copy_ff;

   logic                          o_valid_ff;
   logic [ADDR_BITS-1:0]          o_addr_ff;
   logic signed [SAMPLE_BITS-1:0] o_data_ff;

   logic signed [LW-1:0]          lap_in, base_in;
   logic signed [COEF_W:0]        coef;
   logic signed [PW-1:0]          prod_in;
   logic signed [PW-1:0]          rounded;
   logic signed [RW-1:0]          term;
   logic signed [SW-1:0]          sum;
   logic signed [SAMPLE_BITS-1:0] sum_sat;

   assign lap_in  = LW'(w2_ff) + LW'(cur_in) - (LW'(w1_ff) <<< 1);
   assign base_in = (LW'(w1_ff) <<< 1) - LW'(pv_ff);
   assign coef    = $signed({1'b0, coupling});
   assign prod_in = a_lap_ff * coef;
   assign rounded = b_prod_ff + PW'(32768);
   assign term    = rounded[PW-1:16];
   assign sum     = SW'(b_base_ff) + SW'(term);

   wes_sat #(
      .IN_BITS  (SW),
      .OUT_BITS (SAMPLE_BITS)
   ) u_sat (
      .in_val  (sum),
      .out_val (sum_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= ctl_in.valid && ctl_in.emit;
         b_valid_ff <= a_valid_ff;
         o_valid_ff <= b_valid_ff;
      end
      if (ctl_in.valid) begin
         w1_ff <= cur_in;
         w2_ff <= w1_ff;
         pv_ff <= prev_in;
      end
      a_fixed_ff <= ctl_in.fixed_pt;
      a_addr_ff  <= addr_in;
      a_lap_ff   <= lap_in;
      a_base_ff  <= base_in;
      a_copy_ff  <= w1_ff;
      b_fixed_ff <= a_fixed_ff;
      b_addr_ff  <= a_addr_ff;
      b_prod_ff  <= prod_in;
      b_base_ff  <= a_base_ff;
      b_copy_ff  <= a_copy_ff;
      o_addr_ff  <= b_addr_ff;
      o_data_ff  <= b_fixed_ff ? b_copy_ff : sum_sat;
   end

   assign stat.busy     = a_valid_ff || b_valid_ff || o_valid_ff;
   assign stat.wr_valid = o_valid_ff;
   assign wr_addr       = o_addr_ff;
   assign wr_data       = o_data_ff;

endmodule

`default_nettype wire
